### rtl/ril_pkg.sv
package ril_pkg;

   localparam int DATA_W        = 32;
   localparam int POS_W         = 9;
   localparam int CMD_W         = 3;
   localparam int COUNT_OUT_W   = 9;
   localparam int DEPTH_DEFAULT = 256;

   typedef enum logic [CMD_W-1:0] {
      CMD_GET        = 3'd0,
      CMD_SET        = 3'd1,
      CMD_INSERT     = 3'd2,
      CMD_REMOVE     = 3'd3,
      CMD_NOTIFY_DEL = 3'd4,
      CMD_NOTIFY_ADD = 3'd5,
      CMD_CLEAR      = 3'd6
   } cmd_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_SET,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_DEC,
      CELL_INC
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [DATA_W-1:0]  value;
   } cell_ctrl_type;

endpackage

### rtl/ril_cell.sv
module ril_cell #(
   parameter int PW  = ril_pkg::POS_W,
   parameter int IDX = 0
) (
   input  logic                        clock,
   input  ril_pkg::cell_ctrl_type      ctrl,
   input  logic [PW-1:0]               pos,
   input  logic [ril_pkg::DATA_W-1:0]  left_entry,
   input  logic [ril_pkg::DATA_W-1:0]  right_entry,
   output logic [ril_pkg::DATA_W-1:0]  entry
);
   import ril_pkg::*;

   localparam logic [PW-1:0] MY_POS = PW'(IDX);

   logic [DATA_W-1:0] entry_ff;
   logic [DATA_W-1:0] entry_in;
   logic              at_pos;
   logic              above_pos;

   assign at_pos    = (MY_POS == pos);
   assign above_pos = (MY_POS > pos);

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         CELL_SET: begin
            if (at_pos) entry_in = ctrl.value;
         end
         CELL_INSERT: begin
            // The entry at the position and everything above it move up by one.
            if (at_pos) entry_in = ctrl.value;
            else if (above_pos) entry_in = left_entry;
         end
         CELL_REMOVE: begin
            if (at_pos || above_pos) entry_in = right_entry;
         end
         CELL_DEC: begin
            if (entry_ff > ctrl.value) entry_in = entry_ff - DATA_W'(1);
         end
         CELL_INC: begin
            if (entry_ff >= ctrl.value) entry_in = entry_ff + DATA_W'(1);
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

### rtl/renumbering_index_list.sv
// Ordered list of up to DEPTH 32-bit record numbers, held in a row of cells
// that each own one entry and trade it with their neighbors. Every command (get,
// set, insert, remove, both renumber commands, clear) takes effect on the clock
// edge that accepts it, so one command can be taken every cycle unless stalled;
// the only limit is the result register, which holds a result until the receiver
// takes it and stalls the request side only while it is both full and stalled.
module renumbering_index_list #(
   parameter int DEPTH = ril_pkg::DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ril_pkg::CMD_W-1:0]        req_command,
   input  logic [ril_pkg::POS_W-1:0]        req_position,
   input  logic [ril_pkg::DATA_W-1:0]       req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ril_pkg::DATA_W-1:0]       rsp_read_value,
   output logic                             rsp_status,
   output logic [ril_pkg::COUNT_OUT_W-1:0]  rsp_entry_count,
   output logic [ril_pkg::DATA_W-1:0]       rsp_inserts_since_clear
);
   import ril_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] tally_ff, tally_in;
   logic              holding_ff, holding_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rd_ff, rd_in;
   logic              status_ff, status_in;

   logic              accept;
   cmd_type           cmd;
   logic [CMP_W-1:0]  pos_ext;
   logic [CMP_W-1:0]  cnt_ext;
   logic [CMP_W-1:0]  op_pos;
   logic              in_range;
   logic [IDX_W-1:0]  rd_idx;
   logic [DATA_W-1:0] sel_entry;
   cell_ctrl_type     ctrl;
   logic [DATA_W-1:0] cell_q [DEPTH];

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign cmd       = cmd_type'(req_command);
   assign pos_ext   = CMP_W'(req_position);
   assign cnt_ext   = CMP_W'(count_ff);
   assign in_range  = (pos_ext < cnt_ext);
   assign rd_idx    = IDX_W'(pos_ext);
   assign sel_entry = cell_q[rd_idx];

   always_comb begin
      count_in   = count_ff;
      tally_in   = tally_ff;
      holding_in = holding_ff;
      rd_in      = '0;
      status_in  = 1'b0;
      ctrl.op    = CELL_HOLD;
      ctrl.value = req_value;
      op_pos     = pos_ext;
      unique case (cmd)
         CMD_GET: begin
            if (in_range) begin
               rd_in = sel_entry;
            end else begin
               rd_in     = '1;
               status_in = 1'b1;
            end
         end
         CMD_SET: begin
            if (in_range) ctrl.op = CELL_SET;
            else status_in = 1'b1;
         end
         CMD_INSERT: begin
            tally_in   = tally_ff + DATA_W'(1);
            holding_in = 1'b1;
            if (count_ff != '0 && pos_ext <= cnt_ext) begin
               if (count_ff == CNT_W'(DEPTH)) begin
                  status_in = 1'b1;
               end else begin
                  ctrl.op  = CELL_INSERT;
                  count_in = count_ff + CNT_W'(1);
               end
            end else begin
               // Empty list or position past the end: restart with one entry.
               ctrl.op  = CELL_INSERT;
               op_pos   = '0;
               count_in = CNT_W'(1);
            end
         end
         CMD_REMOVE: begin
            if (count_ff == '0) begin
               status_in = 1'b1;
            end else if (in_range && sel_entry == req_value) begin
               ctrl.op  = CELL_REMOVE;
               count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_NOTIFY_DEL: begin
            if (count_ff == '0) status_in = 1'b1;
            else ctrl.op = CELL_DEC;
         end
         CMD_NOTIFY_ADD: begin
            if (!holding_ff) status_in = 1'b1;
            else ctrl.op = CELL_INC;
         end
         CMD_CLEAR: begin
            count_in   = '0;
            tally_in   = '0;
            holding_in = 1'b0;
         end
         default: begin
            status_in = 1'b1;
         end
      endcase
      if (!accept) ctrl.op = CELL_HOLD;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_entry;
      logic [DATA_W-1:0] right_entry;
      if (i == 0) begin : g_first
         assign left_entry = cell_q[i];
      end else begin : g_left
         assign left_entry = cell_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_entry = cell_q[i];
      end else begin : g_right
         assign right_entry = cell_q[i+1];
      end
      ril_cell #(
         .PW  (CMP_W),
         .IDX (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .pos         (op_pos),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_q[i])
      );
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         tally_ff     <= '0;
         holding_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff   <= count_in;
            tally_ff   <= tally_in;
            holding_ff <= holding_in;
         end
      end
   end

   // The result register loads on every accepted command.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff     <= rd_in;
         status_ff <= status_in;
      end
   end

   logic [DATA_W-1:0]      tally_out_ff;
   logic [COUNT_OUT_W-1:0] count_out_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         tally_out_ff <= tally_in;
         count_out_ff <= COUNT_OUT_W'(count_in);
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_read_value          = rd_ff;
   assign rsp_status              = status_ff;
   assign rsp_entry_count         = count_out_ff;
   assign rsp_inserts_since_clear = tally_out_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(DEPTH))
      else $error("entry count exceeds list depth");

   a_holding: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> holding_ff)
      else $error("list holds entries but is not marked in use");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      accept && cmd == CMD_CLEAR |=> count_ff == '0 && tally_ff == '0 && !holding_ff)
      else $error("clear did not empty the list");

   a_insert_tally: assert property (@(posedge clock) disable iff (reset)
      accept && cmd == CMD_INSERT |=> tally_ff == $past(tally_ff) + DATA_W'(1))
      else $error("insert did not advance the insert counter");

   a_get_miss: assert property (@(posedge clock) disable iff (reset)
      accept && cmd == CMD_GET && !in_range |=> rsp_read_value == '1 && rsp_status)
      else $error("out-of-range get did not return the end value with an error");

endmodule
